/* rtl/gdc_pkg.sv */
// Shared types, codes and helpers for the gate door controller.
package gdc_pkg;

    // One-hot controller states
    typedef enum logic [7:0] {
        ST_INIT    = 8'b0000_0001,
        ST_ERROR   = 8'b0000_0010,
        ST_OPENING = 8'b0000_0100,
        ST_CLOSING = 8'b0000_1000,
        ST_OPEN    = 8'b0001_0000,
        ST_CLOSED  = 8'b0010_0000,
        ST_STOPPED = 8'b0100_0000,
        ST_UNKNOWN = 8'b1000_0000
    } state_t;

    // Encoded door state reported on the output word
    localparam logic [2:0] DOOR_INIT    = 3'd0;
    localparam logic [2:0] DOOR_ERROR   = 3'd1;
    localparam logic [2:0] DOOR_OPENING = 3'd2;
    localparam logic [2:0] DOOR_CLOSING = 3'd3;
    localparam logic [2:0] DOOR_OPEN    = 3'd4;
    localparam logic [2:0] DOOR_CLOSED  = 3'd5;
    localparam logic [2:0] DOOR_STOPPED = 3'd6;
    localparam logic [2:0] DOOR_UNKNOWN = 3'd7;

    // Unknown-position handling modes
    localparam logic [1:0] UNK_CLOSE     = 2'd0;
    localparam logic [1:0] UNK_OPEN      = 2'd1;
    localparam logic [1:0] UNK_WAIT_KEY  = 2'd2;
    localparam logic [1:0] UNK_WAIT_BTN  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_STOP_RESUME_MODE = 1'b0;
    localparam logic CFG_UNKNOWN_MODE     = 1'b1;

    // Input sample, limit_closed in the lowest bit
    typedef struct packed {
        logic push_button;
        logic key_close;
        logic key_open;
        logic photocell;
        logic limit_open;
        logic limit_closed;
    } sample_t;

    // Result word, door_state in the lowest bits
    typedef struct packed {
        logic       buzzer;
        logic       motor_close;
        logic       motor_open;
        logic [2:0] door_state;
    } result_t;

    // Mode registers as seen by the next-state logic
    typedef struct packed {
        logic       stop_resume_mode;
        logic [1:0] unknown_mode;
    } mode_cfg_t;

    function automatic logic [2:0] state_code(input state_t st);
        logic [2:0] code;
        case (st)
            ST_INIT:    code = DOOR_INIT;
            ST_ERROR:   code = DOOR_ERROR;
            ST_OPENING: code = DOOR_OPENING;
            ST_CLOSING: code = DOOR_CLOSING;
            ST_OPEN:    code = DOOR_OPEN;
            ST_CLOSED:  code = DOOR_CLOSED;
            ST_STOPPED: code = DOOR_STOPPED;
            ST_UNKNOWN: code = DOOR_UNKNOWN;
            default:    code = DOOR_INIT;
        endcase
        return code;
    endfunction

endpackage

/* rtl/gate_door_controller_fsm_unit.sv */
// Top level of the gate door controller: input register, state, result register.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  s_tdata: one switch/key sample word
//  m_*       out  m_tvalid/m_tready  m_tdata: new door state and drives
//  cfg_*     in   cfg_wr_en          cfg_addr selects register, cfg_data value
//
// Each sample word is taken into an input register; when the output register
// is free, the next-state decode runs against the state register and the
// result lands in the output register. One word per cycle is sustained while
// m_tready is high. A stalled output holds both stages; s_tready stays high
// while stage one is empty or can move on. Reset puts the controller in init,
// clears the last direction and both mode registers.
module gate_door_controller_fsm_unit (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    // [0] limit_closed, [1] limit_open, [2] photocell, [3] key_open,
    // [4] key_close, [5] push_button, [7:6] zero
    input  logic [7:0] s_tdata,

    output logic       m_tvalid,
    input  logic       m_tready,
    // [2:0] door_state, [3] motor_open, [4] motor_close, [5] buzzer, [7:6] zero
    output logic [7:0] m_tdata,

    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [1:0] cfg_data
);

    // mode registers
    logic       stop_resume_mode_reg;
    logic [1:0] unknown_mode_reg;

    // stage one: sampled word
    logic             in_valid_reg;
    gdc_pkg::sample_t in_sample_reg;

    // controller state
    gdc_pkg::state_t state_reg;
    gdc_pkg::state_t state_next;
    logic            last_open_reg;
    logic            last_open_next;

    // stage two: result word
    logic             out_valid_reg;
    gdc_pkg::result_t out_result_reg;
    gdc_pkg::result_t result_next;

    gdc_pkg::mode_cfg_t mode_cfg;

    logic out_free;    // output register can take a word this cycle
    logic advance;     // stage one word moves into the state/result stage
    logic in_take;     // new sample accepted

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    assign mode_cfg.stop_resume_mode = stop_resume_mode_reg;
    assign mode_cfg.unknown_mode     = unknown_mode_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_resume_mode_reg <= 1'b0;
            unknown_mode_reg     <= gdc_pkg::UNK_CLOSE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                gdc_pkg::CFG_STOP_RESUME_MODE: stop_resume_mode_reg <= cfg_data[0];
                gdc_pkg::CFG_UNKNOWN_MODE:     unknown_mode_reg     <= cfg_data;
                default:                       unknown_mode_reg     <= unknown_mode_reg;
            endcase
        end
    end

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_sample_reg <= gdc_pkg::sample_t'(s_tdata[5:0]);
    end

    gdc_next u_next (
        .state          (state_reg),
        .last_open      (last_open_reg),
        .sample         (in_sample_reg),
        .cfg            (mode_cfg),
        .state_next     (state_next),
        .last_open_next (last_open_next),
        .result         (result_next)
    );

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdc_pkg::ST_INIT;
            last_open_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                last_open_reg <= last_open_next;
            end
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_result_reg};

    // motion direction memory agrees with the moving states
    a_opening_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gdc_pkg::ST_OPENING) |-> last_open_reg)
        else $error("opening state without opening direction");

    a_closing_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gdc_pkg::ST_CLOSING) |-> !last_open_reg)
        else $error("closing state with opening direction");

    // state only moves when a word passes into the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg) && $stable(last_open_reg))
        else $error("state changed without a word");

    // a word waiting in stage one is never dropped
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> in_valid_reg && $stable(in_sample_reg))
        else $error("stage one word lost while stalled");

    // output word reflects the state register it was built from
    a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_result_reg.door_state == gdc_pkg::state_code(state_reg))
        else $error("result word disagrees with state");

endmodule

/* rtl/gdc_next.sv */
// Next-state and output decode for one sample of the gate door controller.
module gdc_next (
    input  gdc_pkg::state_t    state,
    input  logic               last_open,
    input  gdc_pkg::sample_t   sample,
    input  gdc_pkg::mode_cfg_t cfg,
    output gdc_pkg::state_t    state_next,
    output logic               last_open_next,
    output gdc_pkg::result_t   result
);

    logic lc, lo, pc, ko, kc, pb;
    logic go_open;

    assign lc = sample.limit_closed;
    assign lo = sample.limit_open;
    assign pc = sample.photocell;
    assign ko = sample.key_open;
    assign kc = sample.key_close;
    assign pb = sample.push_button;

    // button in stopped: resume last motion, or reverse it
    assign go_open = last_open ^ cfg.stop_resume_mode;

    always_comb
    begin
        state_next = state;
        case (state)
            gdc_pkg::ST_INIT:
            begin
                if (lc && lo)
                    state_next = gdc_pkg::ST_ERROR;
                else if (lo)
                    state_next = gdc_pkg::ST_OPEN;
                else if (lc)
                    state_next = gdc_pkg::ST_CLOSED;
                else
                    state_next = gdc_pkg::ST_UNKNOWN;
            end
            gdc_pkg::ST_ERROR:
            begin
                if (lo && !lc)
                    state_next = gdc_pkg::ST_OPEN;
                else if (lc && !lo)
                    state_next = gdc_pkg::ST_CLOSED;
                else if (!lc && !lo && !pc)
                    state_next = gdc_pkg::ST_CLOSING;
            end
            gdc_pkg::ST_OPENING:
            begin
                if (pb)
                    state_next = gdc_pkg::ST_STOPPED;
                else if (lo)
                    state_next = gdc_pkg::ST_OPEN;
            end
            gdc_pkg::ST_CLOSING:
            begin
                if (pb)
                    state_next = gdc_pkg::ST_STOPPED;
                else if (lc)
                    state_next = gdc_pkg::ST_CLOSED;
            end
            gdc_pkg::ST_OPEN:
            begin
                if (kc || pb)
                    state_next = gdc_pkg::ST_CLOSING;
            end
            gdc_pkg::ST_CLOSED:
            begin
                if (ko || pb)
                    state_next = gdc_pkg::ST_OPENING;
            end
            gdc_pkg::ST_STOPPED:
            begin
                if (ko)
                    state_next = gdc_pkg::ST_OPENING;
                else if (kc)
                    state_next = gdc_pkg::ST_CLOSING;
                else if (pb)
                    state_next = go_open ? gdc_pkg::ST_OPENING : gdc_pkg::ST_CLOSING;
            end
            gdc_pkg::ST_UNKNOWN:
            begin
                case (cfg.unknown_mode)
                    gdc_pkg::UNK_CLOSE:
                        state_next = gdc_pkg::ST_CLOSING;
                    gdc_pkg::UNK_OPEN:
                        state_next = gdc_pkg::ST_OPENING;
                    gdc_pkg::UNK_WAIT_KEY:
                    begin
                        if (ko)
                            state_next = gdc_pkg::ST_OPENING;
                        else if (kc)
                            state_next = gdc_pkg::ST_CLOSING;
                    end
                    gdc_pkg::UNK_WAIT_BTN:
                    begin
                        if (pb)
                            state_next = gdc_pkg::ST_CLOSING;
                    end
                    default:
                        state_next = gdc_pkg::ST_CLOSING;
                endcase
            end
            default:
                state_next = gdc_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        last_open_next = last_open;
        if (state_next == gdc_pkg::ST_OPENING)
            last_open_next = 1'b1;
        else if (state_next == gdc_pkg::ST_CLOSING)
            last_open_next = 1'b0;
    end

    assign result.door_state  = gdc_pkg::state_code(state_next);
    assign result.motor_open  = (state_next == gdc_pkg::ST_OPENING);
    assign result.motor_close = (state_next == gdc_pkg::ST_CLOSING);
    assign result.buzzer      = (state_next == gdc_pkg::ST_ERROR);

endmodule
